@@ rtl/tcw_pkg.sv @@
package tcw_pkg;

  // Operation codes
  localparam logic [2:0] FUNC_PUT    = 3'd0;
  localparam logic [2:0] FUNC_SET    = 3'd1;
  localparam logic [2:0] FUNC_CLEAR  = 3'd2;
  localparam logic [2:0] FUNC_PUT_AT = 3'd3;
  localparam logic [2:0] FUNC_READ   = 3'd4;

  // Control characters
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_BLANK     = 8'd0;

  // Configuration registers
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd1;

  localparam logic [3:0] BG_RESET = 4'd3;
  localparam logic [3:0] FG_RESET = 4'd15;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] char_code;
    logic [6:0] pos_col;
    logic [4:0] pos_row;
  } cmd_t;

  typedef struct packed {
    logic        cell_written;
    logic [10:0] cell_address;
    logic [15:0] cell_entry;
    logic        scrolled;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [15:0] read_entry;
  } result_t;

  function automatic logic [15:0] make_entry(logic [3:0] bg, logic [3:0] fg,
                                             logic [7:0] ch);
    return {bg, fg, ch};
  endfunction

  localparam logic [15:0] RESET_BLANK = {BG_RESET, FG_RESET, CHAR_BLANK};

endpackage

@@ rtl/tcw_chan.sv @@
interface tcw_chan #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/text_console_writer.sv @@
// Text-mode screen writer: a ROWS x COLUMNS store of 16-bit cells
// ({background, foreground, char}) plus a cursor.
// cmd: valid/ready channel of tcw_pkg::cmd_t requests (func, char_code,
// pos_col, pos_row). result: valid/ready channel of tcw_pkg::result_t, one
// result per request, in order. cfg_we/cfg_index/cfg_data write the
// background (index 0) and foreground (index 1) colors; write only while idle.
// Requests are handled one at a time. Put, put-at, set cursor and no-op go
// from accept through S_EXEC to the result register; a read passes through
// S_READ as well. The next request is accepted the cycle after the result
// is posted. Clear sweeps the store one cell per cycle.
// A scroll copies (ROWS-1)*COLUMNS cells through the single read and write
// port of the store, then blanks the bottom row. After reset the store is
// blanked in the reset colors, all COLUMNS*ROWS cells (2000 by default),
// during which cmd.ready stays low.
// The result register lets the next request be accepted while a result
// waits; a request that finishes while the result is still stalled holds
// until the receiver takes the older one.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  tcw_chan.sink                         cmd,
  tcw_chan.source                       result,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int IW = $clog2(CELL_COUNT + 1);
  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]    state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic          pend, pend_next;
  logic [AW-1:0] waddr, waddr_next;
  logic          booting, booting_next;

  logic [CW-1:0] cur_col, cur_col_next;
  logic [RW-1:0] cur_row, cur_row_next;
  logic [3:0]    bg, fg;

  logic [2:0]    func_q;
  logic [7:0]    ch_q;
  logic [CW-1:0] pc_q;
  logic [RW-1:0] pr_q;

  logic          res_written, res_written_next;
  logic [AW-1:0] res_addr, res_addr_next;
  logic [15:0]   res_entry, res_entry_next;
  logic          res_scrolled, res_scrolled_next;
  logic [15:0]   res_read, res_read_next;

  logic          o_valid;
  result_t       o_data;

  logic [15:0]   mem [CELL_COUNT];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0]   mem_wd, mem_rd;

  logic          cmd_fire, slot_free, finish, post;
  logic [15:0]   blank;
  logic [AW-1:0] read_addr;

  // put-char evaluation
  logic [CW-1:0] pc_col;
  logic [RW-1:0] pc_row;
  logic          pc_we, pc_scroll;
  logic [AW-1:0] pc_addr;
  logic [15:0]   pc_entry;

  assign cmd_fire   = cmd.valid && cmd.ready;
  assign cmd.ready  = (state == S_IDLE);
  assign slot_free  = !o_valid || result.ready;
  assign blank      = make_entry(bg, fg, CHAR_BLANK);
  assign read_addr  = AW'(pr_q) * AW'(COLUMNS) + AW'(pc_q);
  assign result.valid = o_valid;
  assign result.data  = o_data;

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd <= mem[mem_ra];
  end

  always_comb begin : put_char_logic
    logic [CW-1:0] wc;
    logic [RW-1:0] wr;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic [CW-1:0] a_col;
    logic [RW-1:0] a_row;
    wc = (func_q == FUNC_PUT_AT) ? pc_q : cur_col;
    wr = (func_q == FUNC_PUT_AT) ? pr_q : cur_row;
    col_inc = {1'b0, wc} + (CW+1)'(1);
    row_inc = {1'b0, wr} + (RW+1)'(1);
    pc_col = wc;
    pc_row = wr;
    pc_we = 1'b0;
    pc_scroll = 1'b0;
    pc_entry = make_entry(bg, fg, ch_q);
    a_col = wc;
    a_row = wr;
    case (ch_q)
      CHAR_NEWLINE: begin
        pc_col = '0;
        if (row_inc >= (RW+1)'(ROWS)) begin
          pc_row = RW'(ROWS - 1);
          pc_scroll = 1'b1;
        end else begin
          pc_row = row_inc[RW-1:0];
        end
      end
      CHAR_BACKSPACE: begin
        pc_we = 1'b1;
        pc_entry = blank;
        if (wc != '0) begin
          pc_col = wc - CW'(1);
        end else if (wr != '0) begin
          pc_col = CW'(COLUMNS - 1);
          pc_row = wr - RW'(1);
        end
        a_col = pc_col;
        a_row = pc_row;
      end
      default: begin
        pc_we = 1'b1;
        if (col_inc >= (CW+1)'(COLUMNS)) begin
          pc_col = '0;
          if (row_inc >= (RW+1)'(ROWS)) begin
            pc_row = RW'(ROWS - 1);
            pc_scroll = 1'b1;
          end else begin
            pc_row = row_inc[RW-1:0];
          end
        end else begin
          pc_col = col_inc[CW-1:0];
        end
      end
    endcase
    pc_addr = AW'(a_row) * AW'(COLUMNS) + AW'(a_col);
  end

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    pend_next         = 1'b0;
    waddr_next        = waddr;
    booting_next      = booting;
    cur_col_next      = cur_col;
    cur_row_next      = cur_row;
    res_written_next  = res_written;
    res_addr_next     = res_addr;
    res_entry_next    = res_entry;
    res_scrolled_next = res_scrolled;
    res_read_next     = res_read;
    mem_we            = 1'b0;
    mem_wa            = waddr;
    mem_wd            = mem_rd;
    mem_ra            = idx[AW-1:0];
    finish            = 1'b0;
    post              = 1'b0;

    case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          state_next        = S_EXEC;
          res_written_next  = 1'b0;
          res_addr_next     = '0;
          res_entry_next    = '0;
          res_scrolled_next = 1'b0;
          res_read_next     = '0;
        end
      end
      S_EXEC: begin
        case (func_q)
          FUNC_PUT, FUNC_PUT_AT: begin
            mem_we            = pc_we;
            mem_wa            = pc_addr;
            mem_wd            = pc_entry;
            res_written_next  = pc_we;
            res_addr_next     = pc_we ? pc_addr : '0;
            res_entry_next    = pc_we ? pc_entry : '0;
            res_scrolled_next = pc_scroll;
            if (func_q == FUNC_PUT) begin
              cur_col_next = pc_col;
              cur_row_next = pc_row;
            end
            if (pc_scroll) begin
              state_next = S_SCROLL;
              idx_next   = IW'(COLUMNS);
            end else begin
              finish = 1'b1;
            end
          end
          FUNC_SET: begin
            cur_col_next = pc_q;
            cur_row_next = pr_q;
            finish       = 1'b1;
          end
          FUNC_CLEAR: begin
            cur_col_next = '0;
            cur_row_next = '0;
            idx_next     = '0;
            state_next   = S_FILL;
          end
          FUNC_READ: begin
            mem_ra     = read_addr;
            state_next = S_READ;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_READ: begin
        res_read_next = mem_rd;
        finish        = 1'b1;
      end
      S_SCROLL: begin
        // read row r+1 while writing the previous word one row up
        mem_we = pend;
        if (idx != IW'(CELL_COUNT)) begin
          pend_next  = 1'b1;
          waddr_next = idx[AW-1:0] - AW'(COLUMNS);
          idx_next   = idx + IW'(1);
        end else begin
          idx_next   = IW'((ROWS - 1) * COLUMNS);
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        mem_wa = idx[AW-1:0];
        mem_wd = booting ? RESET_BLANK : blank;
        if (idx == IW'(CELL_COUNT - 1)) begin
          if (booting) begin
            booting_next = 1'b0;
            state_next   = S_IDLE;
          end else begin
            finish = 1'b1;
          end
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      S_DONE: begin
        finish = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (finish) begin
      if (slot_free) begin
        post       = 1'b1;
        state_next = S_IDLE;
      end else begin
        state_next = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_FILL;
      idx     <= '0;
      pend    <= 1'b0;
      booting <= 1'b1;
      cur_col <= '0;
      cur_row <= '0;
      bg      <= BG_RESET;
      fg      <= FG_RESET;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      pend    <= pend_next;
      booting <= booting_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_BACKGROUND: bg <= cfg_data;
          REG_FOREGROUND: fg <= cfg_data;
          default: ;
        endcase
      end
      if (post) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    waddr        <= waddr_next;
    res_written  <= res_written_next;
    res_addr     <= res_addr_next;
    res_entry    <= res_entry_next;
    res_scrolled <= res_scrolled_next;
    res_read     <= res_read_next;
    if (cmd_fire) begin
      func_q <= cmd.data.func;
      ch_q   <= cmd.data.char_code;
      pc_q   <= (cmd.data.pos_col > 7'(COLUMNS - 1)) ? CW'(COLUMNS - 1)
                                                     : cmd.data.pos_col[CW-1:0];
      pr_q   <= (cmd.data.pos_row > 5'(ROWS - 1)) ? RW'(ROWS - 1)
                                                  : cmd.data.pos_row[RW-1:0];
    end
    if (post) begin
      o_data.cell_written <= res_written_next;
      o_data.cell_address <= 11'(res_addr_next);
      o_data.cell_entry   <= res_entry_next;
      o_data.scrolled     <= res_scrolled_next;
      o_data.cursor_col   <= 7'(cur_col_next);
      o_data.cursor_row   <= 5'(cur_row_next);
      o_data.read_entry   <= res_read_next;
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_col <= CW'(COLUMNS - 1)) && (cur_row <= RW'(ROWS - 1)))
    else $error("cursor outside the screen");

  a_scroll_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL && mem_we && pend_next) |-> (mem_wa != mem_ra))
    else $error("scroll copy reads and writes the same cell");

  a_pend_in_scroll: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_SCROLL))
    else $error("pending copy word outside scroll");

  a_boot_fill: assert property (@(posedge clk) disable iff (rst)
    booting |-> (state == S_FILL && !o_valid))
    else $error("request handling during reset clearing pass");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (o_valid && !result.ready) |=> (o_valid && $stable(o_data)))
    else $error("stalled result overwritten");

endmodule
